// File: design/wps_pkg.sv
// wps_pkg: shared types, constants and helpers for the wavetable phase sampler.
// No dependencies; used by every design file but wps_ram through scoped names.

package wps_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = IDX_W + 1;
  localparam int CFG_W       = 11;
  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int MOD_STEPS   = 32;
  localparam int CNT_W       = $clog2(MOD_STEPS);
  localparam int Q_DEPTH     = 4;
  localparam int QPTR_W      = $clog2(Q_DEPTH);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_NEXT  = 2'd2;

  localparam logic [CFG_W-1:0] LENGTH_RESET = CFG_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_START,
    OP_NEXT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] step;
    logic [WORD_W-1:0] scale;
  } op_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // clamp the length register to 1..TABLE_DEPTH
  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] len);
    logic [LEN_W-1:0] r;
    if (len == '0) begin
      r = LEN_W'(1);
    end else if (32'(len) > TABLE_DEPTH) begin
      r = LEN_W'(TABLE_DEPTH);
    end else begin
      r = LEN_W'(len);
    end
    return r;
  endfunction

endpackage

// File: design/wavetable_phase_sampler_unit.sv
// wavetable_phase_sampler_unit: top level of the wavetable oscillator.
// Depends on wps_pkg, wps_front, wps_queue and wps_back.
//
//   channel   handshake              word
//   in        in_valid / in_stall    command, table_index, table_value,
//                                    start_phase, step, step_scale
//   out       out_valid / out_stall  sample, phase_after
//   cfg       cfg_valid / cfg_ready  table_length
//
// Write and next words issue one per cycle if no start word runs (next words
// also wait on a stalled output); a next result is registered in s1, then in
// the output. A start word runs a multiply, then the bit-serial remainder.
// Reset is synchronous on rst and needs no clearing pass; table entries are
// undefined until written. A stalled output holds its word while up to four
// words still queue on the input side.

module wavetable_phase_sampler_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          command,
  input  logic [9:0]                          table_index,
  input  logic signed [wps_pkg::WORD_W-1:0]   table_value,
  input  logic [wps_pkg::WORD_W-1:0]          start_phase,
  input  logic [wps_pkg::WORD_W-1:0]          step,
  input  logic [wps_pkg::WORD_W-1:0]          step_scale,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wps_pkg::WORD_W-1:0]   sample,
  output logic [wps_pkg::WORD_W-1:0]          phase_after,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wps_pkg::CFG_W-1:0]           table_length
);

  logic [wps_pkg::CFG_W-1:0]  length_reg;
  logic [wps_pkg::LEN_W-1:0]  eff_len;
  logic                       push;
  logic                       pop;
  wps_pkg::op_word_t          push_word;
  wps_pkg::op_word_t          head;
  wps_pkg::q_status_t         q_stat;

  assign cfg_ready = 1'b1;
  assign eff_len   = wps_pkg::eff_len(length_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg <= wps_pkg::LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length_reg <= table_length;
    end
  end

  wps_front u_front (
    .in_valid    (in_valid),
    .command     (command),
    .table_index (table_index),
    .table_value (table_value),
    .start_phase (start_phase),
    .step        (step),
    .step_scale  (step_scale),
    .q_full      (q_stat.full),
    .in_stall    (in_stall),
    .push        (push),
    .push_word   (push_word)
  );

  wps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .status    (q_stat)
  );

  wps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .len         (eff_len),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .phase_after (phase_after)
  );

`ifndef ASSERT_OFF
  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (33'(phase_after) < 33'({eff_len, 16'b0})))
    else $error("phase_after not below table length");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_stall_is_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !q_stat.empty && !pop || q_stat.full)
    else $error("input stalled while queue has room");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

// File: design/wps_ram.sv
// wps_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module wps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/wps_front.sv
// wps_front: input acceptance and command decode into operation words.
// Depends on wps_pkg.

module wps_front (
  input  logic                          in_valid,
  input  logic [1:0]                    command,
  input  logic [9:0]                    table_index,
  input  logic [wps_pkg::WORD_W-1:0]    table_value,
  input  logic [wps_pkg::WORD_W-1:0]    start_phase,
  input  logic [wps_pkg::WORD_W-1:0]    step,
  input  logic [wps_pkg::WORD_W-1:0]    step_scale,
  input  logic                          q_full,
  output logic                          in_stall,
  output logic                          push,
  output wps_pkg::op_word_t             push_word
);

  logic keep;

  assign in_stall = q_full;

  always_comb begin
    keep            = 1'b0;
    push_word.op    = wps_pkg::OP_NEXT;
    push_word.index = wps_pkg::IDX_W'(table_index);
    push_word.data  = start_phase;
    push_word.step  = step;
    push_word.scale = step_scale;
    unique case (command)
      wps_pkg::CMD_WRITE: begin
        keep           = 32'(table_index) < wps_pkg::TABLE_DEPTH;
        push_word.op   = wps_pkg::OP_WRITE;
        push_word.data = table_value;
      end
      wps_pkg::CMD_START: begin
        keep         = 1'b1;
        push_word.op = wps_pkg::OP_START;
      end
      wps_pkg::CMD_NEXT: begin
        keep         = 1'b1;
        push_word.op = wps_pkg::OP_NEXT;
      end
      default: keep = 1'b0;
    endcase
  end

  // drop unused codes and out-of-range writes
  assign push = in_valid && !q_full && keep;

endmodule

// File: design/wps_queue.sv
// wps_queue: short FIFO of operation words between decode and execution.
// Depends on wps_pkg.

module wps_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wps_pkg::op_word_t    push_word,
  input  logic                 pop,
  output wps_pkg::op_word_t    head,
  output wps_pkg::q_status_t   status
);

  wps_pkg::op_word_t             entries [wps_pkg::Q_DEPTH];
  logic [wps_pkg::QPTR_W-1:0]    wr_ptr;
  logic [wps_pkg::QPTR_W-1:0]    rd_ptr;
  logic [wps_pkg::QPTR_W:0]      count;
  logic                          do_push;
  logic                          do_pop;

  assign status.full  = count == (wps_pkg::QPTR_W+1)'(wps_pkg::Q_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_word;
        wr_ptr          <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/wps_back.sv
// wps_back: executes operation words: table writes, run start with increment
// multiply and bit-serial length reduction, and per-sample phase advance.
// Depends on wps_pkg and wps_ram.

module wps_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [wps_pkg::LEN_W-1:0]        len,
  input  wps_pkg::op_word_t                head,
  input  wps_pkg::q_status_t               q_stat,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [wps_pkg::WORD_W-1:0] sample,
  output logic [wps_pkg::WORD_W-1:0]       phase_after
);

  localparam int W  = wps_pkg::WORD_W;
  localparam int FW = wps_pkg::FRAC_W;
  localparam int LW = wps_pkg::LEN_W;

  typedef enum logic [1:0] {
    S_RUN,
    S_MUL,
    S_MOD
  } state_t;

  state_t                     state;
  logic [W-1:0]               phase;
  logic [W-1:0]               incr;
  logic [W-1:0]               st;
  logic [W-1:0]               sc;
  logic [FW-1:0]              sp_frac;
  logic [FW-1:0]              inc_frac;
  logic [W-1:0]               num_p;
  logic [W-1:0]               num_i;
  logic [LW-1:0]              rem_p;
  logic [LW-1:0]              rem_i;
  logic [wps_pkg::CNT_W-1:0]  cnt;
  logic                       s1_valid;
  logic [W-1:0]               s1_phase;

  logic                       s1_adv;
  logic                       next_ok;
  logic                       is_next;
  logic                       is_write;
  logic [W:0]                 lenq;
  logic [W-1:0]               p_cur;
  logic [W:0]                 sum;
  logic [W:0]                 sum_sub;
  logic [W-1:0]               phase_next;
  logic [LW-1:0]              rem_p_next;
  logic [LW-1:0]              rem_i_next;
  logic [W-1:0]               rdata;
  logic [2*W-1:0]             product;

  function automatic logic [LW-1:0] mod_step(input logic [LW-1:0] rem, input logic b,
                                             input logic [LW-1:0] l);
    logic [LW-1:0] sh;
    sh = {rem[LW-2:0], b};
    return (sh >= l) ? sh - l : sh;
  endfunction

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign next_ok  = !s1_valid || s1_adv;
  assign is_next  = head.op == wps_pkg::OP_NEXT;
  assign is_write = head.op == wps_pkg::OP_WRITE;
  assign pop      = (state == S_RUN) && !q_stat.empty && (!is_next || next_ok);

  assign lenq       = (W+1)'({len, FW'(0)});
  assign p_cur      = ((W+1)'(phase) >= lenq) ? '0 : phase;
  assign sum        = (W+1)'(p_cur) + (W+1)'(incr);
  assign sum_sub    = (sum >= lenq) ? sum - lenq : sum;
  assign phase_next = (sum_sub >= lenq) ? '0 : sum_sub[W-1:0];

  assign rem_p_next = mod_step(rem_p, num_p[W-1], len);
  assign rem_i_next = mod_step(rem_i, num_i[W-1], len);
  assign product    = (2*W)'(st) * (2*W)'(sc);

  wps_ram #(
    .WIDTH (W),
    .DEPTH (wps_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (pop && is_write),
    .waddr (head.index),
    .wdata (head.data),
    .re    (pop && is_next),
    .raddr (p_cur[FW +: wps_pkg::IDX_W]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      phase     <= '0;
      incr      <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_RUN: begin
          if (pop && head.op == wps_pkg::OP_START) begin
            st      <= head.step;
            sc      <= head.scale;
            num_p   <= W'(head.data[W-1:FW]);
            sp_frac <= head.data[FW-1:0];
            state   <= S_MUL;
          end else if (pop && is_next) begin
            phase <= phase_next;
          end
        end
        S_MUL: begin
          num_i    <= product[2*W-1:W];
          inc_frac <= product[W-1:FW];
          rem_p    <= '0;
          rem_i    <= '0;
          cnt      <= wps_pkg::CNT_W'(wps_pkg::MOD_STEPS - 1);
          state    <= S_MOD;
        end
        S_MOD: begin
          rem_p <= rem_p_next;
          rem_i <= rem_i_next;
          num_p <= {num_p[W-2:0], 1'b0};
          num_i <= {num_i[W-2:0], 1'b0};
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            phase <= W'({rem_p_next, sp_frac});
            incr  <= W'({rem_i_next, inc_frac});
            state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase

      if (pop && is_next) begin
        s1_valid <= 1'b1;
        s1_phase <= phase_next;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        out_valid   <= 1'b1;
        sample      <= rdata;
        phase_after <= s1_phase;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
